[rtl/tcpg_pkg.sv]
// Shared constants, types and address helpers for the text cell pixel generator.
package tcpg_pkg;

  localparam int FontBytes = 8192;
  localparam int FontIdxW  = $clog2(FontBytes);
  localparam int AddrW     = 13;

  localparam logic OpLoad   = 1'b0;
  localparam logic OpRender = 1'b1;

  localparam logic [AddrW-1:0] LowBankBase  = 13'h1000;
  localparam logic [AddrW-1:0] HighBankBase = 13'h1800;
  localparam logic [7:0]       NormalLevel  = 8'hAA;
  localparam logic [7:0]       IntenseLevel = 8'hFF;

  typedef struct packed {
    logic                we;
    logic [FontIdxW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [FontIdxW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] attr;
  } cell_t;

  function automatic logic [FontIdxW-1:0] store_index(input logic [AddrW-1:0] a);
    logic [AddrW:0] wide;
    logic [AddrW:0] red;
    wide = {1'b0, a};
    red  = (wide >= (AddrW+1)'(FontBytes)) ? wide - (AddrW+1)'(FontBytes) : wide;
    return red[FontIdxW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] glyph_addr(input logic [7:0] chr,
                                                   input logic [4:0] line);
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] row;
    base = line[3] ? HighBankBase : LowBankBase;
    row  = line[3] ? AddrW'(line[2:0]) : AddrW'(line);
    return base + AddrW'({chr, 3'b000}) + row;
  endfunction

endpackage

[rtl/tcpg_font_ram.sv]
// Font store: single write port, single registered read port.
module tcpg_font_ram (
  input  logic              clk,
  input  tcpg_pkg::ram_req_t req,
  output logic [7:0]        rdata
);

  logic [7:0] mem_r [tcpg_pkg::FontBytes];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem_r[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/tcpg_pixel_shifter.sv]
// Pixel serializer: shifts one font byte out as eight colored pixels.
module tcpg_pixel_shifter (
  input  logic                clk,
  input  logic                rst_n,
  input  tcpg_pkg::cell_t     cell_in,
  input  logic [7:0]          font_byte,
  output logic                take,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_pixel_index,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue,
  output logic                out_last_pixel
);

  logic       valid_r, valid_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [7:0] bits_r, bits_nxt;
  logic [7:0] attr_r, attr_nxt;
  logic       last;
  logic       done;
  logic [3:0] nib;
  logic [7:0] level;

  assign last = (idx_r == 3'd7);
  assign done = out_ready && last;
  assign take = !valid_r || done;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    bits_nxt  = bits_r;
    attr_nxt  = attr_r;
    if (take && cell_in.valid) begin
      valid_nxt = 1'b1;
      idx_nxt   = 3'd0;
      bits_nxt  = font_byte;
      attr_nxt  = cell_in.attr;
    end else if (done) begin
      valid_nxt = 1'b0;
    end else if (valid_r && out_ready) begin
      idx_nxt  = idx_r + 3'd1;
      bits_nxt = {bits_r[6:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 3'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r <= bits_nxt;
    attr_r <= attr_nxt;
  end

  assign nib   = bits_r[7] ? attr_r[3:0] : attr_r[7:4];
  assign level = nib[3] ? tcpg_pkg::IntenseLevel : tcpg_pkg::NormalLevel;

  assign out_valid       = valid_r;
  assign out_pixel_index = idx_r;
  assign out_blue        = nib[0] ? level : 8'h00;
  assign out_green       = nib[1] ? level : 8'h00;
  assign out_red         = nib[2] ? level : 8'h00;
  assign out_last_pixel  = last;

endmodule

[rtl/text_cell_pixel_generator_core.sv]
// Top level of the text cell pixel generator.
//
// Input channel (in_valid/in_ready): a load transaction (opcode 0) writes
// in_font_data into the 8 KiB font store at in_font_address; it produces
// no output. A render transaction (opcode 1) looks up one font byte from
// char_code and scan_line and yields eight pixel transactions on the
// output channel (out_valid/out_ready), leftmost pixel first, with
// out_last_pixel on the eighth.
// The first pixel is presented once the render has passed the font read
// and lookup stage, registered at acceptance, and then the serializer
// load, which waits until the serializer can take a new cell.
// Throughput: loads go at one per cycle while in_ready is high; renders are
// paced by the serializer, one pixel per cycle while out_ready is high.
// One render waits in the lookup stage while the previous one streams.
// Reset clears the pipeline valid bits and the pixel index only; the
// font store holds garbage until written and needs no clearing pass.
// A stalled receiver holds the current pixel; in_ready drops once the
// lookup stage is occupied and the serializer cannot reload.
module text_cell_pixel_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [12:0] in_font_address,
  input  logic [7:0]  in_font_data,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_attribute,
  input  logic [4:0]  in_scan_line,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_pixel_index,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_last_pixel
);

  tcpg_pkg::ram_req_t req;
  tcpg_pkg::cell_t    s1_cell;
  logic               s1_valid_r, s1_valid_nxt;
  logic [7:0]         s1_attr_r, s1_attr_nxt;
  logic [7:0]         font_byte;
  logic               take;
  logic               in_acc;
  logic               render_acc;

  assign in_ready   = !s1_valid_r || take;
  assign in_acc     = in_valid && in_ready;
  assign render_acc = in_acc && (in_opcode == tcpg_pkg::OpRender);

  always_comb begin
    req.we    = in_acc && (in_opcode == tcpg_pkg::OpLoad);
    req.waddr = tcpg_pkg::store_index(in_font_address);
    req.wdata = in_font_data;
    req.re    = render_acc;
    req.raddr = tcpg_pkg::store_index(tcpg_pkg::glyph_addr(in_char_code, in_scan_line));
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_attr_nxt  = s1_attr_r;
    if (render_acc) begin
      s1_valid_nxt = 1'b1;
      s1_attr_nxt  = in_attribute;
    end else if (take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_attr_r <= s1_attr_nxt;
  end

  assign s1_cell.valid = s1_valid_r;
  assign s1_cell.attr  = s1_attr_r;

  tcpg_font_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (font_byte)
  );

  tcpg_pixel_shifter u_shift (
    .clk             (clk),
    .rst_n           (rst_n),
    .cell_in         (s1_cell),
    .font_byte       (font_byte),
    .take            (take),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_index (out_pixel_index),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_last_pixel  (out_last_pixel)
  );

endmodule

[rtl/tcpg_checker.sv]
// Port-level checks for the text cell pixel generator, bound to the top level.
module tcpg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_pixel_index,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       out_last_pixel
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_index) &&
      $stable(out_red) && $stable(out_green) && $stable(out_blue))
    else $error("stalled pixel transaction changed");

  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_pixel |=>
      out_valid && (out_pixel_index == 3'($past(out_pixel_index) + 3'd1)))
    else $error("pixel sequence broken inside a cell");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_pixel == (out_pixel_index == 3'd7)))
    else $error("last pixel flag misplaced");

  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red == 8'h00 || out_red == 8'hAA || out_red == 8'hFF) &&
      (out_green == 8'h00 || out_green == 8'hAA || out_green == 8'hFF) &&
      (out_blue == 8'h00 || out_blue == 8'hAA || out_blue == 8'hFF))
    else $error("illegal color level");

endmodule

bind text_cell_pixel_generator_core tcpg_checker u_tcpg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pixel_index (out_pixel_index),
  .out_red         (out_red),
  .out_green       (out_green),
  .out_blue        (out_blue),
  .out_last_pixel  (out_last_pixel)
);

[tb/text_cell_pixel_generator_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for text_cell_pixel_generator_core: font loads and cell renders.
module text_cell_pixel_generator_core_tb;

  localparam int CycleLimit = 1_000_000;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic        op;
    logic [12:0] addr;
    logic [7:0]  data;
    logic [7:0]  chr;
    logic [7:0]  attr;
    logic [4:0]  line;
    logic        lit;
    logic [7:0]  lit_red;
    logic [7:0]  lit_green;
    logic [7:0]  lit_blue;
  } cell_txn_t;

  typedef struct packed {
    logic [2:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_opcode;
  logic [12:0] in_font_address;
  logic [7:0]  in_font_data;
  logic [7:0]  in_char_code;
  logic [7:0]  in_attribute;
  logic [4:0]  in_scan_line;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_pixel_index;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        out_last_pixel;

  logic [7:0] font_mirror [tcpg_pkg::FontBytes];
  bit         font_written [tcpg_pkg::FontBytes];
  pixel_t     pixel_queue [$];
  int         error_count = 0;
  int         cycle_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_left = 0;
  bit         hold_req = 1'b0;

  cell_txn_t directed_txns [24] = '{
    '{tcpg_pkg::OpLoad,   13'h1000, 8'hFF, 8'h00, 8'h00, 5'd0,  1'b0, 8'h00, 8'h00, 8'h00},
    '{tcpg_pkg::OpLoad,   13'h120B, 8'hA5, 8'h00, 8'h00, 5'd0,  1'b0, 8'h00, 8'h00, 8'h00},
    '{tcpg_pkg::OpLoad,   13'h1FFF, 8'h00, 8'h00, 8'h00, 5'd0,  1'b0, 8'h00, 8'h00, 8'h00},
    '{tcpg_pkg::OpLoad,   13'h0000, 8'h5A, 8'h00, 8'h00, 5'd0,  1'b0, 8'h00, 8'h00, 8'h00},
    '{tcpg_pkg::OpLoad,   13'h1800, 8'h81, 8'h00, 8'h00, 5'd0,  1'b0, 8'h00, 8'h00, 8'h00},
    '{tcpg_pkg::OpLoad,   13'h1010, 8'h3C, 8'h00, 8'h00, 5'd0,  1'b0, 8'h00, 8'h00, 8'h00},
    '{tcpg_pkg::OpLoad,   13'h180F, 8'hF0, 8'h00, 8'h00, 5'd0,  1'b0, 8'h00, 8'h00, 8'h00},
    '{tcpg_pkg::OpRender, 13'h0000, 8'h00, 8'h00, 8'h0F, 5'd0,  1'b1, 8'hFF, 8'hFF, 8'hFF},
    '{tcpg_pkg::OpRender, 13'h1FFF, 8'hFF, 8'h00, 8'h07, 5'd0,  1'b1, 8'hAA, 8'hAA, 8'hAA},
    '{tcpg_pkg::OpRender, 13'h0000, 8'h00, 8'h00, 8'h01, 5'd0,  1'b1, 8'h00, 8'h00, 8'hAA},
    '{tcpg_pkg::OpRender, 13'h0000, 8'h00, 8'h00, 8'h0C, 5'd0,  1'b1, 8'hFF, 8'h00, 8'h00},
    '{tcpg_pkg::OpRender, 13'h0000, 8'h00, 8'h00, 8'hF0, 5'd0,  1'b1, 8'h00, 8'h00, 8'h00},
    '{tcpg_pkg::OpRender, 13'h0000, 8'h00, 8'hFF, 8'h70, 5'd15, 1'b1, 8'hAA, 8'hAA, 8'hAA},
    '{tcpg_pkg::OpRender, 13'h0000, 8'h00, 8'hFF, 8'hF0, 5'd31, 1'b1, 8'hFF, 8'hFF, 8'hFF},
    '{tcpg_pkg::OpRender, 13'h0000, 8'h00, 8'hFF, 8'h8F, 5'd15, 1'b1, 8'h00, 8'h00, 8'h00},
    '{tcpg_pkg::OpRender, 13'h0000, 8'h00, 8'h41, 8'h1E, 5'd3,  1'b0, 8'h00, 8'h00, 8'h00},
    '{tcpg_pkg::OpRender, 13'h0000, 8'h00, 8'h00, 8'h4A, 5'd8,  1'b0, 8'h00, 8'h00, 8'h00},
    '{tcpg_pkg::OpRender, 13'h0000, 8'h00, 8'h00, 8'hA5, 5'd16, 1'b0, 8'h00, 8'h00, 8'h00},
    '{tcpg_pkg::OpRender, 13'h0000, 8'h00, 8'hFF, 8'h9B, 5'd23, 1'b0, 8'h00, 8'h00, 8'h00},
    '{tcpg_pkg::OpRender, 13'h0000, 8'h00, 8'h01, 8'h2C, 5'd15, 1'b0, 8'h00, 8'h00, 8'h00},
    '{tcpg_pkg::OpLoad,   13'h1000, 8'h00, 8'h00, 8'h00, 5'd0,  1'b0, 8'h00, 8'h00, 8'h00},
    '{tcpg_pkg::OpRender, 13'h0000, 8'h00, 8'h00, 8'h70, 5'd0,  1'b0, 8'h00, 8'h00, 8'h00},
    '{tcpg_pkg::OpLoad,   13'h1FFF, 8'hFF, 8'h00, 8'h00, 5'd0,  1'b0, 8'h00, 8'h00, 8'h00},
    '{tcpg_pkg::OpRender, 13'h0000, 8'h00, 8'hFF, 8'h07, 5'd15, 1'b1, 8'hAA, 8'hAA, 8'hAA}
  };

  text_cell_pixel_generator_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_font_address (in_font_address),
    .in_font_data    (in_font_data),
    .in_char_code    (in_char_code),
    .in_attribute    (in_attribute),
    .in_scan_line    (in_scan_line),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_index (out_pixel_index),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_last_pixel  (out_last_pixel)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int glyph_slot(input logic [7:0] chr, input logic [4:0] line);
    logic [12:0] addr;
    if (line[3]) begin
      addr = tcpg_pkg::HighBankBase + {2'b00, chr, 3'b000} + {10'b0, line[2:0]};
    end else begin
      addr = tcpg_pkg::LowBankBase + {2'b00, chr, 3'b000} + {8'b0, line};
    end
    return int'(addr) % tcpg_pkg::FontBytes;
  endfunction

  function automatic logic [23:0] rgb_of(input logic [3:0] nib);
    logic [7:0] level;
    level = nib[3] ? tcpg_pkg::IntenseLevel : tcpg_pkg::NormalLevel;
    return {nib[2] ? level : 8'h00, nib[1] ? level : 8'h00, nib[0] ? level : 8'h00};
  endfunction

  function automatic void predict_cell(input logic [7:0] chr, input logic [7:0] attr,
                                       input logic [4:0] line);
    logic [7:0]  glyph;
    logic [23:0] fg;
    logic [23:0] bg;
    pixel_t      px;
    glyph = font_mirror[glyph_slot(chr, line)];
    fg = rgb_of(attr[3:0]);
    bg = rgb_of(attr[7:4]);
    for (int i = 0; i < 8; i++) begin
      px.idx = 3'(i);
      {px.red, px.green, px.blue} = glyph[7-i] ? fg : bg;
      px.last = (i == 7);
      pixel_queue.push_back(px);
    end
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_txn(input cell_txn_t txn);
    pixel_t px;
    int     slot;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= txn.op;
    in_font_address <= txn.addr;
    in_font_data    <= txn.data;
    in_char_code    <= txn.chr;
    in_attribute    <= txn.attr;
    in_scan_line    <= txn.line;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (txn.op == tcpg_pkg::OpLoad) begin
      slot = int'(txn.addr) % tcpg_pkg::FontBytes;
      font_mirror[slot] = txn.data;
      font_written[slot] = 1'b1;
    end else if (txn.lit) begin
      for (int i = 0; i < 8; i++) begin
        px = '{3'(i), txn.lit_red, txn.lit_green, txn.lit_blue, i == 7};
        pixel_queue.push_back(px);
      end
    end else begin
      predict_cell(txn.chr, txn.attr, txn.line);
    end
    @(negedge clk);
  endtask

  // mostly renders, each preceded by a glyph load when its slot is unwritten, with stray loads across the whole store
  task automatic run_random(input int count);
    cell_txn_t txn;
    int        slot;
    for (int n = 0; n < count; n++) begin
      txn      = '0;
      txn.chr  = 8'($urandom_range(255));
      txn.attr = 8'($urandom_range(255));
      txn.line = 5'($urandom_range(31));
      txn.data = 8'($urandom_range(255));
      if ($urandom_range(99) < 25) begin
        txn.op   = tcpg_pkg::OpLoad;
        txn.addr = $urandom_range(1) ? 13'($urandom_range(8191))
                                     : 13'(32'h1000 + $urandom_range(4095));
        send_txn(txn);
      end else begin
        slot = glyph_slot(txn.chr, txn.line);
        if (!font_written[slot]) begin
          txn.op   = tcpg_pkg::OpLoad;
          txn.addr = 13'(slot);
          send_txn(txn);
          n++;
        end
        txn.op   = tcpg_pkg::OpRender;
        txn.addr = 13'($urandom_range(8191));
        txn.data = 8'($urandom_range(255));
        send_txn(txn);
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[text_cell_pixel_generator_core] ERROR");
      $finish;
    end else if (rst_n && out_valid && out_ready) begin
      if (pixel_queue.size() == 0) begin
        $error("unexpected pixel transaction, index %0d", out_pixel_index);
        error_count++;
      end else begin
        want = pixel_queue.pop_front();
        if (out_pixel_index !== want.idx) begin
          $error("pixel_index: expected %0d, actual %0d", want.idx, out_pixel_index);
          error_count++;
        end
        if (out_red !== want.red) begin
          $error("red: expected %0h, actual %0h", want.red, out_red);
          error_count++;
        end
        if (out_green !== want.green) begin
          $error("green: expected %0h, actual %0h", want.green, out_green);
          error_count++;
        end
        if (out_blue !== want.blue) begin
          $error("blue: expected %0h, actual %0h", want.blue, out_blue);
          error_count++;
        end
        if (out_last_pixel !== want.last) begin
          $error("last_pixel: expected %0b, actual %0b", want.last, out_last_pixel);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_opcode       = tcpg_pkg::OpLoad;
    in_font_address = '0;
    in_font_data    = '0;
    in_char_code    = '0;
    in_attribute    = '0;
    in_scan_line    = '0;
    send_idle_pct   = 29;
    recv_stall_pct  = 68;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed_txns[k]) send_txn(directed_txns[k]);
    run_random(167);
    send_idle_pct  = 68;
    recv_stall_pct = 29;
    run_random(167);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // long receiver hold-off while renders keep coming
    hold_req = 1'b1;
    run_random(166);
    in_valid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("[text_cell_pixel_generator_core] OK");
    end else begin
      $display("[text_cell_pixel_generator_core] ERROR");
    end
    $finish;
  end

endmodule
